// ===== rtl/motion_command_line_parser_defines.svh =====
// assertion macros for the top-level rtl file
`ifndef MOTION_COMMAND_LINE_PARSER_DEFINES_SVH
`define MOTION_COMMAND_LINE_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCLP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mclp check failed");

// next-cycle implication, checked outside reset
`define MCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mclp check failed");

`endif

// ===== rtl/mclp_pkg.sv =====
package mclp_pkg;

    // line geometry
    localparam int LINE_KEEP = 7;
    localparam int IDX_W     = $clog2(LINE_KEEP);
    localparam int CNT_W     = 4;
    localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;
    localparam int PAT_COUNT = 7;
    localparam int PAT_LEN   = 5;

    // special characters
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_W     = 8'h57;

    // command kinds
    localparam logic [3:0] KIND_INVALID    = 4'd0;
    localparam logic [3:0] KIND_FWD        = 4'd1;
    localparam logic [3:0] KIND_BACK       = 4'd2;
    localparam logic [3:0] KIND_STOP       = 4'd3;
    localparam logic [3:0] KIND_FWD_INDEF  = 4'd4;
    localparam logic [3:0] KIND_BACK_INDEF = 4'd5;
    localparam logic [3:0] KIND_L90        = 4'd6;
    localparam logic [3:0] KIND_R90        = 4'd7;
    localparam logic [3:0] KIND_L90_BACK   = 4'd8;
    localparam logic [3:0] KIND_R90_BACK   = 4'd9;

    // fixed command tails, first character in the top byte
    localparam logic [8*PAT_LEN-1:0] PAT_TEXT [PAT_COUNT] = '{
        "STOP-", "FW---", "BW---", "FL090", "FR090", "BL090", "BR090"
    };
    localparam logic [3:0] PAT_KIND [PAT_COUNT] = '{
        KIND_STOP, KIND_FWD_INDEF, KIND_BACK_INDEF,
        KIND_L90, KIND_R90, KIND_L90_BACK, KIND_R90_BACK
    };

    typedef struct packed {
        logic [LINE_KEEP-1:0][7:0] chars;
        logic [CNT_W-1:0]          trim_len;
    } t_line;

    typedef struct packed {
        logic       cmd_valid;
        logic [3:0] command_kind;
        logic [3:0] detection_tens;
        logic [3:0] detection_ones;
        logic [9:0] distance_units;
        logic       indefinite;
    } t_result;

    function automatic logic is_term(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== rtl/mclp_line_buf.sv =====
module mclp_line_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_byte,
    output mclp_pkg::t_line     o_line
);

    logic [mclp_pkg::LINE_KEEP-1:0][7:0] r_chars;
    logic [mclp_pkg::CNT_W-1:0]          r_seen;
    logic [mclp_pkg::CNT_W-1:0]          r_trim;
    logic [mclp_pkg::CNT_W-1:0]          n_seen;
    logic [mclp_pkg::CNT_W-1:0]          n_trim;
    logic                                term;

    assign term = mclp_pkg::is_term(i_byte);

    // saturating count and position of the last non-space
    always_comb begin
        n_seen = r_seen;
        n_trim = r_trim;
        if (term) begin
            n_seen = '0;
            n_trim = '0;
        end else begin
            if (r_seen != mclp_pkg::COUNT_MAX) begin
                n_seen = r_seen + 1'b1;
            end
            if (i_byte != mclp_pkg::CH_SPACE) begin
                n_trim = n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_trim <= '0;
        end else if (i_en) begin
            r_seen <= n_seen;
            r_trim <= n_trim;
        end
    end

    // keep the first characters of the line
    always_ff @(posedge i_clk) begin
        if (i_en && !term && (r_seen < mclp_pkg::CNT_W'(mclp_pkg::LINE_KEEP))) begin
            r_chars[r_seen[mclp_pkg::IDX_W-1:0]] <= i_byte;
        end
    end

    assign o_line.chars    = r_chars;
    assign o_line.trim_len = r_trim;

endmodule

// ===== rtl/mclp_decode.sv =====
module mclp_decode (
    input  mclp_pkg::t_line   i_line,
    output mclp_pkg::t_result o_result
);

    logic [8*mclp_pkg::PAT_LEN-1:0] tail;
    logic                           head_ok;
    logic [3:0]                     pat_kind;
    logic                           dist_ok;
    logic [3:0]                     kind;
    logic [9:0]                     dist_val;

    // command tail, first character in the top byte
    assign tail = {i_line.chars[2], i_line.chars[3], i_line.chars[4],
                   i_line.chars[5], i_line.chars[6]};

    assign head_ok = (i_line.trim_len == mclp_pkg::CNT_W'(mclp_pkg::LINE_KEEP))
                   && mclp_pkg::is_digit(i_line.chars[0])
                   && mclp_pkg::is_digit(i_line.chars[1]);

    // fixed tails are distinct, at most one hits
    always_comb begin
        pat_kind = mclp_pkg::KIND_INVALID;
        for (int p = 0; p < mclp_pkg::PAT_COUNT; p++) begin
            if (tail == mclp_pkg::PAT_TEXT[p]) begin
                pat_kind = mclp_pkg::PAT_KIND[p];
            end
        end
    end

    // forward or backward with a three-digit distance
    assign dist_ok = ((i_line.chars[2] == mclp_pkg::CH_F) || (i_line.chars[2] == mclp_pkg::CH_B))
                   && (i_line.chars[3] == mclp_pkg::CH_W)
                   && mclp_pkg::is_digit(i_line.chars[4])
                   && mclp_pkg::is_digit(i_line.chars[5])
                   && mclp_pkg::is_digit(i_line.chars[6]);

    always_comb begin
        kind = mclp_pkg::KIND_INVALID;
        dist_val = '0;
        if (head_ok) begin
            if (pat_kind != mclp_pkg::KIND_INVALID) begin
                kind = pat_kind;
            end else if (dist_ok) begin
                kind = (i_line.chars[2] == mclp_pkg::CH_F) ? mclp_pkg::KIND_FWD
                                                           : mclp_pkg::KIND_BACK;
                dist_val = {6'd0, i_line.chars[4][3:0]} * 10'd100
                         + {6'd0, i_line.chars[5][3:0]} * 10'd10
                         + {6'd0, i_line.chars[6][3:0]};
            end
        end
    end

    // everything zero on an invalid line
    always_comb begin
        o_result = '0;
        if (kind != mclp_pkg::KIND_INVALID) begin
            o_result.cmd_valid      = 1'b1;
            o_result.command_kind   = kind;
            o_result.detection_tens = i_line.chars[0][3:0];
            o_result.detection_ones = i_line.chars[1][3:0];
            o_result.distance_units = dist_val;
            o_result.indefinite     = (kind == mclp_pkg::KIND_FWD_INDEF)
                                   || (kind == mclp_pkg::KIND_BACK_INDEF);
        end
    end

endmodule

// ===== rtl/motion_command_line_parser.sv =====
// Motion command line parser. Takes one character word per cycle and emits one
// result word for every line terminator (CR, LF or NUL), with the command kind,
// the two detection digits, the distance and the indefinite flag, all zero for
// an illegal line. A line terminator waits in the input register, then the line
// it ends goes through the decoder into the result register. The block
// sustains one character per cycle; the only thing that holds the input is a
// terminator waiting in the input register while the result register is full
// and stalled. Ordinary characters only update the line buffer and pass even
// while a result waits.
`include "motion_command_line_parser_defines.svh"

module motion_command_line_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_cmd_valid,
    output logic [3:0] o_command_kind,
    output logic [3:0] o_detection_tens,
    output logic [3:0] o_detection_ones,
    output logic [9:0] o_distance_units,
    output logic       o_indefinite
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_out_vld;
    mclp_pkg::t_result r_out;
    logic              in_term;
    logic              out_free;
    logic              advance;
    mclp_pkg::t_line   line;
    mclp_pkg::t_result result;

    assign in_term  = mclp_pkg::is_term(r_in_byte);
    assign out_free = !r_out_vld || !i_stall;
    assign advance  = r_in_vld && (!in_term || out_free);
    assign o_stall  = r_in_vld && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_char_byte;
        end
    end

    mclp_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .o_line  (line)
    );

    mclp_decode u_decode (
        .i_line   (line),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= advance && in_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && in_term) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_cmd_valid      = r_out.cmd_valid;
    assign o_command_kind   = r_out.command_kind;
    assign o_detection_tens = r_out.detection_tens;
    assign o_detection_ones = r_out.detection_ones;
    assign o_distance_units = r_out.distance_units;
    assign o_indefinite     = r_out.indefinite;

    // consistency of the result word and of the pipeline control
    `MCLP_ASSERT_SAME(a_valid_kind, i_clk, i_rst_n, r_out_vld, r_out.cmd_valid == (r_out.command_kind != mclp_pkg::KIND_INVALID))
    `MCLP_ASSERT_SAME(a_indef_kind, i_clk, i_rst_n, r_out_vld && r_out.indefinite, (r_out.command_kind == mclp_pkg::KIND_FWD_INDEF) || (r_out.command_kind == mclp_pkg::KIND_BACK_INDEF))
    `MCLP_ASSERT_SAME(a_dist_kind, i_clk, i_rst_n, r_out_vld && (r_out.distance_units != 10'd0), (r_out.command_kind == mclp_pkg::KIND_FWD) || (r_out.command_kind == mclp_pkg::KIND_BACK))
    `MCLP_ASSERT_NEXT(a_plain_no_out, i_clk, i_rst_n, r_in_vld && !in_term && out_free, !r_out_vld)
    `MCLP_ASSERT_SAME(a_empty_no_stall, i_clk, i_rst_n, !r_in_vld, !o_stall)

endmodule
